// ===== design/can_frame_ascii_encoder_macros.svh =====
// Assertion macros for the CAN frame ASCII encoder.
// Each macro expands to a labeled concurrent assertion in simulation and to nothing in synthesis.
`ifndef CAN_FRAME_ASCII_ENCODER_MACROS_SVH
`define CAN_FRAME_ASCII_ENCODER_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define CFAE_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("cfae assertion failed (same cycle)");

// The consequent must hold in the cycle after the antecedent.
`define CFAE_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("cfae assertion failed (next cycle)");

`else

`define CFAE_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons)
`define CFAE_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons)

`endif

`endif

// ===== design/cfae_pkg.sv =====
package cfae_pkg;

	// Frame limits.
	localparam int unsigned MAX_DATA_BYTES = 8;
	// Timestamp reduction: 60000 = 32 * 1875, and x / 1875 equals (x * TS_RECIP) >> 38 for
	// every 27-bit x.
	localparam logic [10:0] TS_DIV_ODD     = 11'd1875;
	localparam logic [27:0] TS_RECIP       = 28'd146601551;
	// Index of the first of the two reduction steps.
	localparam logic [4:0]  TS_TOP_STEP    = 5'd1;

	// Last digit indexes of the counted fields.
	localparam logic [3:0] ID_LAST_EXT = 4'd7;
	localparam logic [3:0] ID_LAST_STD = 4'd2;
	localparam logic [3:0] TS_LAST     = 4'd3;

	// ASCII codes.
	localparam logic [6:0] CHAR_EXT_DATA = 7'h54;  // T
	localparam logic [6:0] CHAR_EXT_RTR  = 7'h52;  // R
	localparam logic [6:0] CHAR_STD_DATA = 7'h74;  // t
	localparam logic [6:0] CHAR_STD_RTR  = 7'h72;  // r
	localparam logic [6:0] CHAR_CR       = 7'h0D;
	localparam logic [6:0] CHAR_ZERO     = 7'h30;
	localparam logic [6:0] CHAR_UPPER_A  = 7'h41;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TYPE,
		ST_ID,
		ST_LEN,
		ST_DATA,
		ST_TS,
		ST_CR
	} state_t;

	// Source of the character loaded into the output register.
	typedef enum logic [2:0] {
		SEL_TYPE,
		SEL_ID,
		SEL_LEN,
		SEL_DATA,
		SEL_TS,
		SEL_CR
	} char_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic      load;
		logic      emit;
		char_sel_t sel;
		logic [3:0] idx;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic       in_ok;
		logic       ext;
		logic       rtr;
		logic [3:0] dlc;
		logic       ts_en;
		logic       ts_done;
		logic       out_free;
	} dp_stat_t;

	// Uppercase hex digit for one nibble.
	function automatic logic [6:0] hex_char(input logic [3:0] nib);
		logic [6:0] wide;
		wide = {3'b000, nib};
		if (nib < 4'd10) begin
			return CHAR_ZERO + wide;
		end
		return CHAR_UPPER_A + wide - 7'd10;
	endfunction

endpackage

// ===== design/cfae_dp.sv =====
module cfae_dp
	import cfae_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	// Input frame fields
	input  logic         in_ext,
	input  logic         in_rtr,
	input  logic         in_err,
	input  logic [28:0]  in_id,
	input  logic [3:0]   in_dlc,
	input  logic [63:0]  in_data,
	input  logic [31:0]  in_tick,
	// Configuration
	input  logic         cfg_wr_en,
	input  logic         cfg_wr_data,
	// Control
	input  dp_cmd_t      cmd,
	output dp_stat_t     stat,
	// Output register
	input  logic         out_ready,
	output logic         out_valid,
	output logic [6:0]   out_char,
	output logic         out_last
);

	logic        ext_q;
	logic        rtr_q;
	logic [3:0]  dlc_q;
	logic [31:0] id_q;
	logic [63:0] data_q;
	logic [31:0] tick_q;
	logic [16:0] quo_q;
	logic [15:0] rem_q;
	logic [4:0]  stp_q;
	logic        ts_busy_q;
	logic        ts_en_q;
	logic        out_valid_q;
	logic [6:0]  out_char_q;
	logic        out_last_q;

	logic [54:0] ts_prod;
	logic [27:0] ts_back;
	logic [27:0] ts_rest;
	logic [31:0] id_sh;
	logic [63:0] data_sh;
	logic [15:0] ts_sh;
	logic [6:0]  char_d;
	logic        out_free;

	function automatic logic [2:0] idx_id(input logic [3:0] idx);
		return idx[2:0];
	endfunction

	// Frame capture; only the low 11 identifier bits count for standard frames.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ext_q  <= in_ext;
			rtr_q  <= in_rtr;
			dlc_q  <= in_dlc;
			id_q   <= in_ext ? {3'b000, in_id} : {21'd0, in_id[10:0]};
			data_q <= in_data;
		end
	end

	// Tick modulo 60000: with tick = 32 * x plus five low bits, the result is (x mod 1875) * 32
	// plus those bits. The first step takes x / 1875 by a reciprocal multiply (scaled by 2^38),
	// the second takes the remainder by a multiply and subtract.
	assign ts_prod = {28'd0, tick_q[31:5]} * {27'd0, TS_RECIP};
	assign ts_back = {11'd0, quo_q} * {17'd0, TS_DIV_ODD};
	assign ts_rest = {1'b0, tick_q[31:5]} - ts_back;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tick_q <= in_tick;
		end else if (ts_busy_q) begin
			if (stp_q != 5'd0) begin
				quo_q <= ts_prod[54:38];
			end else begin
				rem_q <= {ts_rest[10:0], tick_q[4:0]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_busy_q <= 1'b0;
			stp_q     <= '0;
		end else if (cmd.load) begin
			ts_busy_q <= 1'b1;
			stp_q     <= TS_TOP_STEP;
		end else if (ts_busy_q) begin
			if (stp_q == 5'd0) begin
				ts_busy_q <= 1'b0;
			end else begin
				stp_q <= stp_q - 5'd1;
			end
		end
	end

	// Timestamp enable register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_en_q <= 1'b1;
		end else if (cfg_wr_en) begin
			ts_en_q <= cfg_wr_data;
		end
	end

	// Nibble selection; payload digits come high nibble first within each byte.
	assign id_sh   = id_q >> {idx_id(cmd.idx), 2'b00};
	assign data_sh = data_q >> {cmd.idx ^ 4'b0001, 2'b00};
	assign ts_sh   = rem_q >> {cmd.idx[1:0], 2'b00};

	// Character for the current position of the line.
	always_comb begin
		case (cmd.sel)
			SEL_TYPE: begin
				if (ext_q) begin
					char_d = rtr_q ? CHAR_EXT_RTR : CHAR_EXT_DATA;
				end else begin
					char_d = rtr_q ? CHAR_STD_RTR : CHAR_STD_DATA;
				end
			end
			SEL_ID:   char_d = hex_char(id_sh[3:0]);
			SEL_LEN:  char_d = hex_char(dlc_q);
			SEL_DATA: char_d = hex_char(data_sh[3:0]);
			SEL_TS:   char_d = hex_char(ts_sh[3:0]);
			SEL_CR:   char_d = CHAR_CR;
			default:  char_d = CHAR_CR;
		endcase
	end

	// Output register: a new character loads when the slot is empty or being taken.
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_char_q <= char_d;
			out_last_q <= (cmd.sel == SEL_CR);
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;

	// Status to the controller.
	assign stat.in_ok    = !in_err && (in_dlc != 4'd0) && (in_dlc <= 4'(MAX_DATA_BYTES));
	assign stat.ext      = ext_q;
	assign stat.rtr      = rtr_q;
	assign stat.dlc      = dlc_q;
	assign stat.ts_en    = ts_en_q;
	assign stat.ts_done  = !ts_busy_q;
	assign stat.out_free = out_free;

endmodule

// ===== design/cfae_ctrl.sv =====
module cfae_ctrl
	import cfae_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t     state_q;
	state_t     state_d;
	logic [3:0] cnt_q;
	logic [3:0] cnt_d;
	logic [4:0] data_end;

	// Index of the last payload digit: two digits per byte.
	assign data_end = {stat.dlc, 1'b0} - 5'd1;

	// State and digit counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		in_ready = 1'b0;
		cmd.load = 1'b0;
		cmd.emit = 1'b0;
		cmd.sel  = SEL_CR;
		cmd.idx  = cnt_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (stat.in_ok) begin
						state_d = ST_TYPE;
					end
				end
			end
			ST_TYPE: begin
				cmd.sel = SEL_TYPE;
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cnt_d    = stat.ext ? ID_LAST_EXT : ID_LAST_STD;
					state_d  = ST_ID;
				end
			end
			ST_ID: begin
				cmd.sel = SEL_ID;
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (cnt_q == 4'd0) begin
						state_d = ST_LEN;
					end else begin
						cnt_d = cnt_q - 4'd1;
					end
				end
			end
			ST_LEN: begin
				cmd.sel = SEL_LEN;
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (stat.rtr) begin
						cnt_d   = TS_LAST;
						state_d = stat.ts_en ? ST_TS : ST_CR;
					end else begin
						cnt_d   = 4'd0;
						state_d = ST_DATA;
					end
				end
			end
			ST_DATA: begin
				cmd.sel = SEL_DATA;
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (cnt_q == data_end[3:0]) begin
						cnt_d   = TS_LAST;
						state_d = stat.ts_en ? ST_TS : ST_CR;
					end else begin
						cnt_d = cnt_q + 4'd1;
					end
				end
			end
			ST_TS: begin
				cmd.sel = SEL_TS;
				// Digits wait for the modulo reduction to finish.
				if (stat.out_free && stat.ts_done) begin
					cmd.emit = 1'b1;
					if (cnt_q == 4'd0) begin
						state_d = ST_CR;
					end else begin
						cnt_d = cnt_q - 4'd1;
					end
				end
			end
			ST_CR: begin
				cmd.sel = SEL_CR;
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== design/can_frame_ascii_encoder.sv =====
// Turns one received CAN frame into its serial-line ASCII text, one character per output beat:
// 'T'/'R' and 8 hex identifier digits (extended) or 't'/'r' and 3 digits (standard), the
// length digit, the payload as uppercase hex (data frames only), an optional 4-digit
// timestamp (tick modulo 60000, enabled after reset) and a closing carriage return marked
// by tlast. Error frames and length codes of 0 or above 8 are taken and give no output.
// One frame is handled at a time: the input is ready only between lines, once the closing
// carriage return has been loaded, and a dropped frame leaves the block waiting for the next
// frame. The longest line has 31 characters. A waiting character that is not taken holds the
// line back. The timestamp comes from a modulo unit that is done while the type and identifier
// characters leave, so it never delays the line.

`include "can_frame_ascii_encoder_macros.svh"

module can_frame_ascii_encoder
	import cfae_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	// Frame input
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [135:0] s_axis_tdata,  // can_id[28:0], length_code[32:29], payload[96:33],
	                                    // tick_ms[128:97], zero fill
	input  logic [2:0]   s_axis_tuser,  // is_extended[0], is_remote[1], is_error[2]
	// Character output
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [7:0]   m_axis_tdata,  // out_char[6:0], zero fill
	output logic         m_axis_tlast,  // last_char
	// Timestamp enable register
	input  logic         cfg_wr_en,
	input  logic         cfg_wr_data
);

	dp_cmd_t    cmd;
	dp_stat_t   stat;
	logic [6:0] out_char;

	cfae_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	cfae_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ext      (s_axis_tuser[0]),
		.in_rtr      (s_axis_tuser[1]),
		.in_err      (s_axis_tuser[2]),
		.in_id       (s_axis_tdata[28:0]),
		.in_dlc      (s_axis_tdata[32:29]),
		.in_data     (s_axis_tdata[96:33]),
		.in_tick     (s_axis_tdata[128:97]),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.stat        (stat),
		.out_ready   (m_axis_tready),
		.out_valid   (m_axis_tvalid),
		.out_char    (out_char),
		.out_last    (m_axis_tlast)
	);

	assign m_axis_tdata = {1'b0, out_char};

	// A timestamp digit is never taken before the modulo reduction is done.
	`CFAE_ASSERT_IMP(a_ts_ready, clk, arst_n, cmd.emit && (cmd.sel == SEL_TS), stat.ts_done)
	// The controller never overwrites a character that is still waiting.
	`CFAE_ASSERT_IMP(a_no_overwrite, clk, arst_n, cmd.emit, stat.out_free)
	// Loading the carriage return presents a closing beat next cycle.
	`CFAE_ASSERT_NXT(a_cr_last, clk, arst_n, cmd.emit && (cmd.sel == SEL_CR),
		m_axis_tvalid && m_axis_tlast && (m_axis_tdata[6:0] == CHAR_CR))

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

	localparam int CLK_HALF_NS    = 4;
	localparam int RESET_CYCLES   = 8;
	// Margin after the last owed character before the block counts as quiet.
	localparam int SETTLE_CYCLES  = 40;
	localparam int HOLDOFF_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int REPORT_LIMIT   = 10;
	localparam int RANDOM_LINES   = 45;

	localparam int unsigned TICK_WRAP       = 60000;
	localparam int unsigned FRAME_MAX_BYTES = 8;

	// Characters of a text line.
	localparam logic [6:0] ASC_EXT_DATA = 7'h54;
	localparam logic [6:0] ASC_EXT_RTR  = 7'h52;
	localparam logic [6:0] ASC_STD_DATA = 7'h74;
	localparam logic [6:0] ASC_STD_RTR  = 7'h72;
	localparam logic [6:0] ASC_CR       = 7'h0D;
	localparam logic [6:0] ASC_DIGIT_0  = 7'h30;
	localparam logic [6:0] ASC_LETTER_A = 7'h41;

	typedef struct packed {
		bit        extended;
		bit        remote;
		bit        errored;
		bit [28:0] ident;
		bit [3:0]  len_code;
		bit [63:0] bytes8;
		bit [31:0] tick_ms;
	} can_frame_t;

	typedef struct packed {
		logic [6:0] ch;
		logic       last;
	} line_char_t;

	logic         clk           = 1'b0;
	logic         arst_n        = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [135:0] s_axis_tdata  = '0;
	logic [2:0]   s_axis_tuser  = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [7:0]   m_axis_tdata;
	logic         m_axis_tlast;
	logic         cfg_wr_en     = 1'b0;
	logic         cfg_wr_data   = 1'b0;

	// Characters still owed by the block, oldest first.
	line_char_t line_chars_q[$];
	logic       ts_enable_model = 1'b1;

	int tx_idle_pct     = 0;
	int rx_stall_pct    = 0;
	int rx_hold_req     = 0;
	int failure_count   = 0;
	int frames_sent     = 0;
	int silent_frames   = 0;
	int lines_predicted = 0;
	int chars_checked   = 0;
	int lines_checked   = 0;

	can_frame_ascii_encoder i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data)
	);

	initial forever #CLK_HALF_NS clk = ~clk;

	// Counts a failure and reports only the first few.
	task automatic note_failure(input string msg);
		failure_count++;
		if (failure_count <= REPORT_LIMIT) begin
			$display("tb_top: mismatch at %0t: %s", $time, msg);
		end
	endtask

	function automatic logic [6:0] hex_ascii(input logic [3:0] nib);
		if (nib > 4'd9) begin
			return ASC_LETTER_A + {3'b000, nib} - 7'd10;
		end
		return ASC_DIGIT_0 + {3'b000, nib};
	endfunction

	function automatic void push_char(input logic [6:0] ch, input logic last);
		line_char_t c;
		c.ch = ch;
		c.last = last;
		line_chars_q.push_back(c);
	endfunction

	// Queues the value as uppercase hex, most significant digit first.
	function automatic void push_hex(input logic [31:0] value, input int digits);
		int d;
		for (d = digits - 1; d >= 0; d--) begin
			push_char(hex_ascii(value[4*d +: 4]), 1'b0);
		end
	endfunction

	// Queues the text line of one frame; returns 0 when the frame is dropped.
	function automatic bit predict_line(input can_frame_t f);
		logic [31:0] stamp;
		int b;
		if (f.errored || f.len_code == 4'd0 || f.len_code > FRAME_MAX_BYTES) begin
			return 1'b0;
		end
		if (f.extended) begin
			push_char(f.remote ? ASC_EXT_RTR : ASC_EXT_DATA, 1'b0);
			push_hex({3'b000, f.ident}, 8);
		end else begin
			push_char(f.remote ? ASC_STD_RTR : ASC_STD_DATA, 1'b0);
			push_hex({21'd0, f.ident[10:0]}, 3);
		end
		push_char(hex_ascii(f.len_code), 1'b0);
		if (!f.remote) begin
			for (b = 0; b < f.len_code; b++) begin
				push_hex({24'd0, f.bytes8[8*b +: 8]}, 2);
			end
		end
		if (ts_enable_model) begin
			stamp = f.tick_ms % TICK_WRAP;
			push_hex(stamp, 4);
		end
		push_char(ASC_CR, 1'b1);
		return 1'b1;
	endfunction

	function automatic can_frame_t make_frame(input bit ext, input bit rtr, input bit err,
			input bit [28:0] ident, input bit [3:0] len_code, input bit [63:0] bytes8,
			input bit [31:0] tick_ms);
		can_frame_t f;
		f.extended = ext;
		f.remote = rtr;
		f.errored = err;
		f.ident = ident;
		f.len_code = len_code;
		f.bytes8 = bytes8;
		f.tick_ms = tick_ms;
		return f;
	endfunction

	// Mostly well-formed frames; noisy ones are error frames or carry a bad length code.
	function automatic can_frame_t random_frame(input bit noisy);
		can_frame_t f;
		f.extended = 1'($urandom_range(1));
		f.remote = ($urandom_range(4) == 0);
		f.errored = 1'b0;
		f.ident = 29'($urandom);
		f.len_code = 4'($urandom_range(8, 1));
		f.bytes8 = {$urandom, $urandom};
		f.tick_ms = $urandom;
		if (noisy) begin
			case ($urandom_range(2))
				0: begin
					f.errored = 1'b1;
					f.len_code = 4'($urandom_range(15));
				end
				1: begin
					f.len_code = 4'd0;
				end
				default: begin
					f.len_code = 4'($urandom_range(15, 9));
				end
			endcase
		end
		// Now and then a tick at, or one away from, a multiple of the timestamp wrap.
		if ($urandom_range(7) == 0) begin
			f.tick_ms = TICK_WRAP * $urandom_range(71582) + $urandom_range(2) - 1;
		end
		return f;
	endfunction

	// Offers one frame and holds it until the beat is taken. Valid stays high afterwards.
	task automatic send_frame(input can_frame_t f);
		while (int'($urandom_range(99)) < tx_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tdata = {7'd0, f.tick_ms, f.bytes8, f.len_code, f.ident};
		s_axis_tuser = {f.errored, f.remote, f.extended};
		s_axis_tvalid = 1'b1;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		frames_sent++;
		if (predict_line(f)) begin
			lines_predicted++;
		end else begin
			silent_frames++;
		end
		@(negedge clk);
	endtask

	// Stops offering frames and waits until the block has gone quiet.
	task automatic wait_line_drain();
		s_axis_tvalid = 1'b0;
		while (line_chars_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_timestamp_enable(input logic en);
		wait_line_drain();
		cfg_wr_en = 1'b1;
		cfg_wr_data = en;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		ts_enable_model = en;
	endtask

	// Field extremes, every line kind and the dropped frames, timestamp on from reset.
	task automatic test_directed_frames();
		int n;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		send_frame(make_frame(1'b1, 1'b0, 1'b0, 29'h1FFFFFFF, 4'd8, '1, 32'hFFFFFFFF));
		send_frame(make_frame(1'b1, 1'b0, 1'b0, 29'h0, 4'd8, '0, 32'h0));
		send_frame(make_frame(1'b0, 1'b0, 1'b0, 29'h1FFFFFFF, 4'd1, 64'h0123456789ABCDEF,
			32'd59999));
		for (n = 2; n <= 7; n++) begin
			send_frame(make_frame(n[0], 1'b0, 1'b0, 29'(29'h0ABCDEF0 + n), n[3:0],
				n[0] ? {8{8'h55}} : {8{8'hAA}}, TICK_WRAP + n - 4));
		end
		send_frame(make_frame(1'b1, 1'b1, 1'b0, 29'h15555555, 4'd8, '1, TICK_WRAP));
		send_frame(make_frame(1'b0, 1'b1, 1'b0, 29'h0AAAA555, 4'd1, '1, TICK_WRAP + 1));
		send_frame(make_frame(1'b1, 1'b0, 1'b1, 29'h1FFFFFFF, 4'd8, '1, 32'h12345678));
		send_frame(make_frame(1'b0, 1'b1, 1'b1, 29'h123, 4'd3, '0, 32'h0));
		send_frame(make_frame(1'b0, 1'b0, 1'b0, 29'h7FF, 4'd0, '1, 32'h1));
		send_frame(make_frame(1'b1, 1'b1, 1'b0, 29'h7FF, 4'd0, '1, 32'h2));
		send_frame(make_frame(1'b1, 1'b0, 1'b0, 29'h1, 4'd9, '1, 32'h3));
		send_frame(make_frame(1'b0, 1'b1, 1'b0, 29'h2, 4'd15, '1, 32'h4));
		wait_line_drain();
	endtask

	// Lines without the timestamp, then back to the reset setting.
	task automatic test_timestamp_off();
		write_timestamp_enable(1'b0);
		send_frame(make_frame(1'b1, 1'b0, 1'b0, 29'h1FFFFFFF, 4'd8, '1, 32'hFFFFFFFF));
		send_frame(make_frame(1'b0, 1'b1, 1'b0, 29'h1FFFF800, 4'd8, '0, 32'h0));
		send_frame(make_frame(1'b1, 1'b0, 1'b1, 29'h1, 4'd4, '1, 32'h0));
		send_frame(make_frame(1'b0, 1'b0, 1'b0, 29'h5, 4'd15, '1, 32'h0));
		send_frame(make_frame(1'b0, 1'b0, 1'b0, 29'h7FF, 4'd1, 64'hA5, 32'hFFFFFFFF));
		write_timestamp_enable(1'b1);
	endtask

	// The receiver holds off for a long stretch while long lines keep coming.
	task automatic test_output_stall();
		can_frame_t f;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		rx_hold_req++;
		repeat (6) begin
			f = random_frame(1'b0);
			f.extended = 1'b1;
			f.remote = 1'b0;
			f.len_code = 4'd8;
			send_frame(f);
		end
		wait_line_drain();
	endtask

	task automatic test_random_traffic(input int lines, input int tx_pct, input int rx_pct,
			input logic ts_on);
		int start;
		write_timestamp_enable(ts_on);
		tx_idle_pct = tx_pct;
		rx_stall_pct = rx_pct;
		start = lines_predicted;
		while (lines_predicted - start < lines) begin
			send_frame(random_frame($urandom_range(9) == 0));
		end
	endtask

	// Output ready: random stalls, or a long hold-off when one is requested.
	initial begin : rx_ready_drive
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		forever begin
			@(negedge clk);
			if (hold_seen != rx_hold_req) begin
				hold_seen = rx_hold_req;
				hold_left = HOLDOFF_CYCLES;
			end
			if (hold_left > 0) begin
				m_axis_tready = 1'b0;
				hold_left--;
			end else begin
				m_axis_tready = (int'($urandom_range(99)) >= rx_stall_pct);
			end
		end
	end

	// Each output beat is compared with the oldest owed character.
	always @(posedge clk) begin : char_check
		line_char_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (line_chars_q.size() == 0) begin
				note_failure($sformatf("unexpected beat: out_char %h last %b",
					m_axis_tdata, m_axis_tlast));
			end else begin
				want = line_chars_q.pop_front();
				if (m_axis_tdata !== {1'b0, want.ch} || m_axis_tlast !== want.last) begin
					note_failure($sformatf("char %0d: out_char %h last %b, expected %h last %b",
						chars_checked, m_axis_tdata, m_axis_tlast, {1'b0, want.ch}, want.last));
				end
			end
			chars_checked++;
			if (m_axis_tlast) begin
				lines_checked++;
			end
		end
	end

	// Ends the run when neither side has moved a beat for too long.
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("tb_top: no beat for %0d cycles", WATCHDOG_LIMIT);
		$display("tb_top: FAIL");
		$finish;
	end

	initial begin : stimulus
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed_frames();
		test_timestamp_off();
		test_output_stall();
		test_random_traffic(RANDOM_LINES, 6, 55, 1'b1);
		test_random_traffic(RANDOM_LINES, 55, 6, 1'b0);
		test_random_traffic(RANDOM_LINES, 0, 0, 1'b1);
		wait_line_drain();
		if (line_chars_q.size() != 0) begin
			note_failure($sformatf("%0d characters never arrived", line_chars_q.size()));
		end
		$display("tb_top: %0d frames sent (%0d dropped), %0d characters in %0d lines checked",
			frames_sent, silent_frames, chars_checked, lines_checked);
		$display("tb_top: timestamp on and off, %0d-cycle output hold-off, three idle profiles",
			HOLDOFF_CYCLES);
		if (failure_count == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+design
design/cfae_pkg.sv
design/cfae_dp.sv
design/cfae_ctrl.sv
design/can_frame_ascii_encoder.sv
dv/tb_top.sv
